>>> rtl/core/hvac_pkg.sv
// hvac_pkg: shared widths, constants, codes and structs for the thermostat controller
// used by hvac_setpoint_map, hvac_ctrl_core, hvac_thermostat_controller_top and the bench
// no dependencies

package hvac_pkg;

    // field widths
    localparam int unsigned TEMP_W      = 11;
    localparam int unsigned POT_W       = 10;
    localparam int unsigned SETPOINT_W  = 9;
    localparam int unsigned HYST_W      = 7;
    localparam int unsigned LOCK_W      = 18;
    localparam int unsigned RUNDOWN_W   = 15;
    localparam int unsigned DEBOUNCE_W  = 10;
    localparam int unsigned CHANGE_W    = 8;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned COOL_W      = 2;
    localparam int unsigned CFG_DATA_W  = 18;
    localparam int unsigned CFG_INDEX_W = 3;

    // setpoint range defaults and the pot full-scale reading
    localparam int unsigned SETPOINT_MIN_DEF = 180;
    localparam int unsigned SETPOINT_MAX_DEF = 320;
    localparam int unsigned SETPOINT_RESET   = 250;
    localparam int unsigned POT_FULL         = 1023;

    // item kinds
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HYST     = 3'd0,
        REG_LOCK     = 3'd1,
        REG_RUNDOWN  = 3'd2,
        REG_DEBOUNCE = 3'd3,
        REG_WARN     = 3'd4,
        REG_CHANGE   = 3'd5
    } cfg_index_t;

    // one input item
    typedef struct packed {
        logic                  req_type;
        logic                  button_level;
        logic [POT_W-1:0]      pot_value;
        logic [TEMP_W-1:0]     temp_tenths;
        logic                  temp_valid;
    } hvac_item_t;

    // configuration registers as seen by the core
    typedef struct packed {
        logic [HYST_W-1:0]     hysteresis_tenths;
        logic [LOCK_W-1:0]     lock_ms;
        logic [RUNDOWN_W-1:0]  rundown_ms;
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [TEMP_W-1:0]     warn_tenths;
        logic [CHANGE_W-1:0]   change_min_tenths;
    } hvac_cfg_t;

    // status presented as one result item
    typedef struct packed {
        logic                  fan_on;
        logic                  compressor_on;
        logic [COOL_W-1:0]     cool_state;
        logic [MODE_W-1:0]     mode_now;
        logic                  locked_now;
        logic [SETPOINT_W-1:0] setpoint_now;
        logic                  cool_lamp;
        logic                  idle_lamp;
        logic                  warn_lamp;
    } hvac_status_t;

endpackage

>>> rtl/core/hvac_setpoint_map.sv
// hvac_setpoint_map: maps the pot reading to a setpoint and decides whether it is taken
// depends on hvac_pkg

module hvac_setpoint_map #(
    parameter int unsigned SETPOINT_MIN = hvac_pkg::SETPOINT_MIN_DEF,
    parameter int unsigned SETPOINT_MAX = hvac_pkg::SETPOINT_MAX_DEF
) (
    input  logic [hvac_pkg::POT_W-1:0]      pot_value,
    input  logic [hvac_pkg::SETPOINT_W-1:0] setpoint_cur,
    input  logic [hvac_pkg::CHANGE_W-1:0]   change_min,
    output logic [hvac_pkg::SETPOINT_W-1:0] target,
    output logic                            update
);

    localparam int unsigned SPAN    = SETPOINT_MAX - SETPOINT_MIN;
    localparam int unsigned PROD_RAW = $clog2(hvac_pkg::POT_FULL * SPAN + 2);
    localparam int unsigned PROD_W  = (PROD_RAW > hvac_pkg::POT_W + 1) ?
                                      PROD_RAW : hvac_pkg::POT_W + 1;
    localparam int unsigned Q_W     = PROD_W - hvac_pkg::POT_W;
    localparam int unsigned REM_W   = ((Q_W > hvac_pkg::POT_W) ? Q_W : hvac_pkg::POT_W) + 1;
    localparam int unsigned SP_W    = hvac_pkg::SETPOINT_W;

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q_low;
    logic [REM_W-1:0]  rem;
    logic              rem_over;
    logic [Q_W-1:0]    quot;
    logic [SP_W-1:0]   diff;

    // pot * span
    assign prod = PROD_W'(pot_value) * PROD_W'(SPAN);

    // divide by full scale: x = q*(full+1) + low = q*full + (q + low), one correction
    assign q_low    = prod[PROD_W-1:hvac_pkg::POT_W];
    assign rem      = REM_W'(prod[hvac_pkg::POT_W-1:0]) + REM_W'(q_low);
    assign rem_over = (rem >= REM_W'(hvac_pkg::POT_FULL));
    assign quot     = q_low + Q_W'(rem_over);

    assign target = SP_W'(SETPOINT_MIN) + SP_W'(quot);

    // absolute change against the current setpoint
    assign diff   = (target >= setpoint_cur) ? (target - setpoint_cur) : (setpoint_cur - target);
    assign update = (diff > SP_W'(change_min));

endmodule

>>> rtl/core/hvac_ctrl_core.sv
// hvac_ctrl_core: controller state (mode, cooling machine, relays, lockout, counters)
// and its one-item update; depends on hvac_pkg and hvac_setpoint_map

module hvac_ctrl_core #(
    parameter int unsigned SETPOINT_MIN = hvac_pkg::SETPOINT_MIN_DEF,
    parameter int unsigned SETPOINT_MAX = hvac_pkg::SETPOINT_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  hvac_pkg::hvac_item_t  item,
    input  hvac_pkg::hvac_cfg_t   cfg,
    output hvac_pkg::hvac_status_t status
);

    typedef enum logic [hvac_pkg::MODE_W-1:0] {
        MODE_THERMO  = 2'd0,
        MODE_MANUAL  = 2'd1,
        MODE_STANDBY = 2'd2
    } mode_t;

    typedef enum logic [hvac_pkg::COOL_W-1:0] {
        COOL_OFF     = 2'd0,
        COOL_FAN     = 2'd1,
        COOL_FULL    = 2'd2,
        COOL_RUNDOWN = 2'd3
    } cool_t;

    localparam int unsigned TW = hvac_pkg::TEMP_W + 2;

    mode_t                             mode_reg, mode_next;
    cool_t                             cool_reg, cool_next;
    logic                              fan_reg, fan_next;
    logic                              comp_reg, comp_next;
    logic                              lock_reg, lock_next;
    logic [hvac_pkg::LOCK_W-1:0]       since_comp_stop_reg, since_comp_stop_next;
    logic [hvac_pkg::RUNDOWN_W-1:0]    since_rundown_reg, since_rundown_next;
    logic [hvac_pkg::DEBOUNCE_W-1:0]   since_press_reg, since_press_next;
    logic                              prev_button_reg, prev_button_next;
    logic [hvac_pkg::TEMP_W-1:0]       temp_store_reg, temp_store_next;
    logic [hvac_pkg::SETPOINT_W-1:0]   setpoint_reg, setpoint_next;

    logic [hvac_pkg::LOCK_W-1:0]       spc_inc;
    logic [hvac_pkg::RUNDOWN_W-1:0]    srd_inc;
    logic [hvac_pkg::DEBOUNCE_W-1:0]   spr_inc;
    logic                              press;
    logic [hvac_pkg::SETPOINT_W-1:0]   sp_target;
    logic                              sp_update;
    logic [hvac_pkg::TEMP_W-1:0]       temp_new;
    logic signed [TW-1:0]              t_cur;
    logic signed [TW-1:0]              sp_s;
    logic signed [TW-1:0]              upper;
    logic signed [TW-1:0]              lower;

    // pot to setpoint
    hvac_setpoint_map #(
        .SETPOINT_MIN (SETPOINT_MIN),
        .SETPOINT_MAX (SETPOINT_MAX)
    ) u_sp_map (
        .pot_value    (item.pot_value),
        .setpoint_cur (setpoint_reg),
        .change_min   (cfg.change_min_tenths),
        .target       (sp_target),
        .update       (sp_update)
    );

    // saturating millisecond counters, one step ahead
    assign spc_inc = (since_comp_stop_reg == '1) ? since_comp_stop_reg
                                                 : since_comp_stop_reg + 1'b1;
    assign srd_inc = (since_rundown_reg == '1) ? since_rundown_reg : since_rundown_reg + 1'b1;
    assign spr_inc = (since_press_reg == '1) ? since_press_reg : since_press_reg + 1'b1;

    // debounced falling edge of the mode button
    assign press = !item.button_level && prev_button_reg && (spr_inc > cfg.debounce_ms);

    // temperature used by the control step and the hysteresis band
    assign temp_new = item.temp_valid ? item.temp_tenths : temp_store_reg;
    assign t_cur    = signed'({{(TW - hvac_pkg::TEMP_W){temp_new[hvac_pkg::TEMP_W-1]}},
                               temp_new});
    assign sp_s     = signed'(TW'(setpoint_reg));
    assign upper    = sp_s + signed'(TW'(cfg.hysteresis_tenths));
    assign lower    = sp_s - signed'(TW'(cfg.hysteresis_tenths));

    // next state for one item
    always_comb
    begin
        mode_next            = mode_reg;
        cool_next            = cool_reg;
        fan_next             = fan_reg;
        comp_next            = comp_reg;
        lock_next            = lock_reg;
        since_comp_stop_next = since_comp_stop_reg;
        since_rundown_next   = since_rundown_reg;
        since_press_next     = since_press_reg;
        prev_button_next     = prev_button_reg;
        temp_store_next      = temp_store_reg;
        setpoint_next        = setpoint_reg;

        if (go)
        begin
            if (item.req_type == hvac_pkg::REQ_TICK)
            begin
                // millisecond tick
                since_comp_stop_next = spc_inc;
                since_rundown_next   = srd_inc;
                since_press_next     = spr_inc;
                if (press)
                begin
                    since_press_next = '0;
                    case (mode_reg)
                        MODE_THERMO: mode_next = MODE_MANUAL;
                        MODE_MANUAL: mode_next = MODE_STANDBY;
                        default:     mode_next = MODE_THERMO;
                    endcase
                end
                prev_button_next = item.button_level;
                if (sp_update)
                begin
                    setpoint_next = sp_target;
                end
                if (lock_reg && (spc_inc >= cfg.lock_ms))
                begin
                    lock_next = 1'b0;
                end
            end
            else
            begin
                // temperature sample and control step
                temp_store_next = temp_new;
                case (mode_reg)
                    MODE_STANDBY:
                    begin
                        comp_next = 1'b0;
                        fan_next  = 1'b0;
                        cool_next = COOL_OFF;
                    end
                    MODE_MANUAL:
                    begin
                        if (!lock_reg)
                        begin
                            comp_next = 1'b1;
                            fan_next  = 1'b1;
                            cool_next = COOL_FULL;
                        end
                    end
                    default:
                    begin
                        case (cool_reg)
                            COOL_OFF:
                            begin
                                if (t_cur > upper)
                                begin
                                    fan_next = 1'b1;
                                    if (!lock_reg)
                                    begin
                                        comp_next = 1'b1;
                                        cool_next = COOL_FULL;
                                    end
                                    else
                                    begin
                                        cool_next = COOL_FAN;
                                    end
                                end
                            end
                            COOL_FAN:
                            begin
                                if (!lock_reg && (t_cur > upper))
                                begin
                                    comp_next = 1'b1;
                                    cool_next = COOL_FULL;
                                end
                                else if (t_cur <= sp_s)
                                begin
                                    fan_next  = 1'b0;
                                    cool_next = COOL_OFF;
                                end
                            end
                            COOL_FULL:
                            begin
                                // compressor stop starts lockout and rundown
                                if (t_cur <= lower)
                                begin
                                    comp_next            = 1'b0;
                                    lock_next            = 1'b1;
                                    since_comp_stop_next = '0;
                                    since_rundown_next   = '0;
                                    cool_next            = COOL_RUNDOWN;
                                end
                            end
                            default:
                            begin
                                if (since_rundown_reg >= cfg.rundown_ms)
                                begin
                                    fan_next  = 1'b0;
                                    cool_next = COOL_OFF;
                                end
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MODE_THERMO;
            cool_reg            <= COOL_OFF;
            fan_reg             <= 1'b0;
            comp_reg            <= 1'b0;
            lock_reg            <= 1'b0;
            since_comp_stop_reg <= '0;
            since_rundown_reg   <= '0;
            since_press_reg     <= '0;
            prev_button_reg     <= 1'b1;
            temp_store_reg      <= '0;
            setpoint_reg        <= hvac_pkg::SETPOINT_W'(hvac_pkg::SETPOINT_RESET);
        end
        else
        begin
            mode_reg            <= mode_next;
            cool_reg            <= cool_next;
            fan_reg             <= fan_next;
            comp_reg            <= comp_next;
            lock_reg            <= lock_next;
            since_comp_stop_reg <= since_comp_stop_next;
            since_rundown_reg   <= since_rundown_next;
            since_press_reg     <= since_press_next;
            prev_button_reg     <= prev_button_next;
            temp_store_reg      <= temp_store_next;
            setpoint_reg        <= setpoint_next;
        end
    end

    // status straight from state
    assign status.fan_on        = fan_reg;
    assign status.compressor_on = comp_reg;
    assign status.cool_state    = cool_reg;
    assign status.mode_now      = mode_reg;
    assign status.locked_now    = lock_reg;
    assign status.setpoint_now  = setpoint_reg;
    assign status.cool_lamp     = (cool_reg == COOL_FULL);
    assign status.idle_lamp     = (cool_reg == COOL_OFF);
    assign status.warn_lamp     = ($signed(temp_store_reg) > $signed(cfg.warn_tenths));

    // compressor runs exactly in full cooling
    a_comp_full: assert property (@(posedge clk) disable iff (!rst_n)
        comp_reg == (cool_reg == COOL_FULL))
        else $error("compressor relay out of step with cooling state");

    // fan runs in every state but off
    a_fan_state: assert property (@(posedge clk) disable iff (!rst_n)
        fan_reg == (cool_reg != COOL_OFF))
        else $error("fan relay out of step with cooling state");

    // entering rundown always starts the lockout from zero
    a_stop_lock: assert property (@(posedge clk) disable iff (!rst_n)
        (cool_reg == COOL_RUNDOWN && $past(cool_reg) != COOL_RUNDOWN)
        |-> (lock_reg && since_comp_stop_reg == '0))
        else $error("compressor stop without lockout start");

    // control state moves only when an item is processed
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> ($stable(mode_reg) && $stable(cool_reg) && $stable(setpoint_reg)))
        else $error("state changed without an item");

endmodule

>>> rtl/core/hvac_thermostat_controller_top.sv
// Thermostat controller top level: one result item for every input item, in order.
// Throughput is one item per clock while out_stall stays low; an accepted item waits in the
// item register and is processed in the following cycle when the result slot is free, and
// the state update and the result appear together at the next edge. The result is read
// straight from the controller state, which holds while out_stall is high, and the item
// register lets one more item be taken meanwhile. Configuration writes take effect at the
// next edge. Depends on hvac_pkg and hvac_ctrl_core.

module hvac_thermostat_controller_top #(
    parameter int unsigned SETPOINT_MIN = hvac_pkg::SETPOINT_MIN_DEF,
    parameter int unsigned SETPOINT_MAX = hvac_pkg::SETPOINT_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration write port
    input  logic                                cfg_we,
    input  logic [hvac_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hvac_pkg::CFG_DATA_W-1:0]     cfg_data,

    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic                                button_level,
    input  logic [hvac_pkg::POT_W-1:0]          pot_value,
    input  logic signed [hvac_pkg::TEMP_W-1:0]  temp_tenths,
    input  logic                                temp_valid,

    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                fan_on,
    output logic                                compressor_on,
    output logic [hvac_pkg::COOL_W-1:0]         cool_state,
    output logic [hvac_pkg::MODE_W-1:0]         mode_now,
    output logic                                locked_now,
    output logic [hvac_pkg::SETPOINT_W-1:0]     setpoint_now,
    output logic                                cool_lamp,
    output logic                                idle_lamp,
    output logic                                warn_lamp
);

    localparam int unsigned HYST_RESET     = 20;
    localparam int unsigned LOCK_RESET     = 180000;
    localparam int unsigned RUNDOWN_RESET  = 30000;
    localparam int unsigned DEBOUNCE_RESET = 250;
    localparam int unsigned WARN_RESET     = 320;
    localparam int unsigned CHANGE_RESET   = 5;

    hvac_pkg::hvac_cfg_t    cfg_reg;
    hvac_pkg::hvac_item_t   item_reg;
    logic                   item_valid_reg, item_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   in_take;
    logic                   go;
    hvac_pkg::hvac_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hysteresis_tenths <= hvac_pkg::HYST_W'(HYST_RESET);
            cfg_reg.lock_ms           <= hvac_pkg::LOCK_W'(LOCK_RESET);
            cfg_reg.rundown_ms        <= hvac_pkg::RUNDOWN_W'(RUNDOWN_RESET);
            cfg_reg.debounce_ms       <= hvac_pkg::DEBOUNCE_W'(DEBOUNCE_RESET);
            cfg_reg.warn_tenths       <= hvac_pkg::TEMP_W'(WARN_RESET);
            cfg_reg.change_min_tenths <= hvac_pkg::CHANGE_W'(CHANGE_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hvac_pkg::REG_HYST:
                    cfg_reg.hysteresis_tenths <= cfg_data[hvac_pkg::HYST_W-1:0];
                hvac_pkg::REG_LOCK:
                    cfg_reg.lock_ms           <= cfg_data[hvac_pkg::LOCK_W-1:0];
                hvac_pkg::REG_RUNDOWN:
                    cfg_reg.rundown_ms        <= cfg_data[hvac_pkg::RUNDOWN_W-1:0];
                hvac_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_ms       <= cfg_data[hvac_pkg::DEBOUNCE_W-1:0];
                hvac_pkg::REG_WARN:
                    cfg_reg.warn_tenths       <= cfg_data[hvac_pkg::TEMP_W-1:0];
                hvac_pkg::REG_CHANGE:
                    cfg_reg.change_min_tenths <= cfg_data[hvac_pkg::CHANGE_W-1:0];
                default:      ;
            endcase
        end
    end

    // item moves into the core when the result slot is free or being taken
    assign go       = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !go;
    assign in_take  = in_valid && !in_stall;

    assign item_valid_next = in_take ? 1'b1 : (go ? 1'b0 : item_valid_reg);
    assign out_valid_next  = go ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // item register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.req_type     <= req_type;
            item_reg.button_level <= button_level;
            item_reg.pot_value    <= pot_value;
            item_reg.temp_tenths  <= temp_tenths;
            item_reg.temp_valid   <= temp_valid;
        end
    end

    // controller state and update
    hvac_ctrl_core #(
        .SETPOINT_MIN (SETPOINT_MIN),
        .SETPOINT_MAX (SETPOINT_MAX)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .status (status)
    );

    // result item
    assign out_valid     = out_valid_reg;
    assign fan_on        = status.fan_on;
    assign compressor_on = status.compressor_on;
    assign cool_state    = status.cool_state;
    assign mode_now      = status.mode_now;
    assign locked_now    = status.locked_now;
    assign setpoint_now  = status.setpoint_now;
    assign cool_lamp     = status.cool_lamp;
    assign idle_lamp     = status.idle_lamp;
    assign warn_lamp     = status.warn_lamp;

endmodule

>>> bench/hvac_thermostat_controller_top_tb.sv
// testbench for hvac_thermostat_controller_top: directed and random ticks and samples
// checked against a cycle-free model of the thermostat state, one status item per input
// depends on hvac_pkg and hvac_thermostat_controller_top
`timescale 1ns / 100ps

module hvac_thermostat_controller_top_tb;

    // cycles with nothing moving before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int SP_MIN  = int'(hvac_pkg::SETPOINT_MIN_DEF);
    localparam int SP_SPAN = int'(hvac_pkg::SETPOINT_MAX_DEF) -
                             int'(hvac_pkg::SETPOINT_MIN_DEF);

    typedef enum bit [hvac_pkg::MODE_W-1:0] {
        MODE_THERMO  = 2'd0,
        MODE_MANUAL  = 2'd1,
        MODE_STANDBY = 2'd2
    } mode_t;

    typedef enum bit [hvac_pkg::COOL_W-1:0] {
        COOL_OFF     = 2'd0,
        COOL_FAN     = 2'd1,
        COOL_FULL    = 2'd2,
        COOL_RUNDOWN = 2'd3
    } cool_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   cfg_we;
    logic [hvac_pkg::CFG_INDEX_W-1:0]       cfg_index;
    logic [hvac_pkg::CFG_DATA_W-1:0]        cfg_data;
    logic                                   in_valid;
    logic                                   in_stall;
    logic                                   req_type;
    logic                                   button_level;
    logic [hvac_pkg::POT_W-1:0]             pot_value;
    logic signed [hvac_pkg::TEMP_W-1:0]     temp_tenths;
    logic                                   temp_valid;
    logic                                   out_valid;
    logic                                   out_stall;
    logic                                   fan_on;
    logic                                   compressor_on;
    logic [hvac_pkg::COOL_W-1:0]            cool_state;
    logic [hvac_pkg::MODE_W-1:0]            mode_now;
    logic                                   locked_now;
    logic [hvac_pkg::SETPOINT_W-1:0]        setpoint_now;
    logic                                   cool_lamp;
    logic                                   idle_lamp;
    logic                                   warn_lamp;

    // shadow configuration
    bit [hvac_pkg::HYST_W-1:0]              cfg_hyst;
    bit [hvac_pkg::LOCK_W-1:0]              cfg_lock;
    bit [hvac_pkg::RUNDOWN_W-1:0]           cfg_rundown;
    bit [hvac_pkg::DEBOUNCE_W-1:0]          cfg_debounce;
    bit signed [hvac_pkg::TEMP_W-1:0]       cfg_warn;
    bit [hvac_pkg::CHANGE_W-1:0]            cfg_change_min;

    // shadow controller state
    mode_t                                  mode;
    cool_t                                  cool;
    bit                                     fan;
    bit                                     comp;
    bit                                     locked;
    bit [hvac_pkg::LOCK_W-1:0]              since_stop;
    bit [hvac_pkg::RUNDOWN_W-1:0]           since_run;
    bit [hvac_pkg::DEBOUNCE_W-1:0]          since_press;
    bit                                     prev_btn;
    bit signed [hvac_pkg::TEMP_W-1:0]       temp_store;
    bit [hvac_pkg::SETPOINT_W-1:0]          setpoint;

    hvac_pkg::hvac_status_t                 pending_status[$];
    hvac_pkg::hvac_status_t                 want_status;
    int                                     error_count;
    int                                     idle_cycles;
    bit                                     no_idle;

    // random stimulus shaping state
    bit                                     btn_cur;
    int                                     btn_hold;
    int                                     pot_cur;

    hvac_thermostat_controller_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .button_level  (button_level),
        .pot_value     (pot_value),
        .temp_tenths   (temp_tenths),
        .temp_valid    (temp_valid),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fan_on        (fan_on),
        .compressor_on (compressor_on),
        .cool_state    (cool_state),
        .mode_now      (mode_now),
        .locked_now    (locked_now),
        .setpoint_now  (setpoint_now),
        .cool_lamp     (cool_lamp),
        .idle_lamp     (idle_lamp),
        .warn_lamp     (warn_lamp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // cooling machine in auto mode
    function automatic void auto_cooling(input int t);
        int sp;
        int upper;
        int lower;
        sp    = int'(setpoint);
        upper = sp + int'(cfg_hyst);
        lower = sp - int'(cfg_hyst);
        case (cool)
            COOL_OFF:
            begin
                if (t > upper)
                begin
                    fan = 1'b1;
                    if (!locked)
                    begin
                        comp = 1'b1;
                        cool = COOL_FULL;
                    end
                    else
                    begin
                        cool = COOL_FAN;
                    end
                end
            end
            COOL_FAN:
            begin
                if (!locked && t > upper)
                begin
                    comp = 1'b1;
                    cool = COOL_FULL;
                end
                else if (t <= sp)
                begin
                    fan  = 1'b0;
                    cool = COOL_OFF;
                end
            end
            COOL_FULL:
            begin
                if (t <= lower)
                begin
                    comp       = 1'b0;
                    locked     = 1'b1;
                    since_stop = '0;
                    since_run  = '0;
                    cool       = COOL_RUNDOWN;
                end
            end
            default:
            begin
                if (since_run >= cfg_rundown)
                begin
                    fan  = 1'b0;
                    cool = COOL_OFF;
                end
            end
        endcase
    endfunction

    // advance the thermostat by one item and return the status it leaves
    function automatic hvac_pkg::hvac_status_t thermostat_step(
        input hvac_pkg::hvac_item_t item);
        hvac_pkg::hvac_status_t st;
        int target;
        int diff;
        if (item.req_type == hvac_pkg::REQ_TICK)
        begin
            // saturating millisecond counters
            if (since_stop != '1)
                since_stop++;
            if (since_run != '1)
                since_run++;
            if (since_press != '1)
                since_press++;

            // debounced press on the falling level
            if (!item.button_level && prev_btn && since_press > cfg_debounce)
            begin
                since_press = '0;
                case (mode)
                    MODE_THERMO: mode = MODE_MANUAL;
                    MODE_MANUAL: mode = MODE_STANDBY;
                    default:     mode = MODE_THERMO;
                endcase
            end
            prev_btn = item.button_level;

            // pot to setpoint with change threshold
            target = SP_MIN + (int'(item.pot_value) * SP_SPAN) / int'(hvac_pkg::POT_FULL);
            diff   = target - int'(setpoint);
            if (diff < 0)
                diff = -diff;
            if (diff > int'(cfg_change_min))
                setpoint = target[hvac_pkg::SETPOINT_W-1:0];

            // lockout expiry
            if (locked && since_stop >= cfg_lock)
                locked = 1'b0;
        end
        else
        begin
            if (item.temp_valid)
                temp_store = item.temp_tenths;
            case (mode)
                MODE_STANDBY:
                begin
                    comp = 1'b0;
                    fan  = 1'b0;
                    cool = COOL_OFF;
                end
                MODE_MANUAL:
                begin
                    if (!locked)
                    begin
                        comp = 1'b1;
                        fan  = 1'b1;
                        cool = COOL_FULL;
                    end
                end
                default:
                begin
                    auto_cooling(int'(temp_store));
                end
            endcase
        end

        st.fan_on        = fan;
        st.compressor_on = comp;
        st.cool_state    = cool;
        st.mode_now      = mode;
        st.locked_now    = locked;
        st.setpoint_now  = setpoint;
        st.cool_lamp     = (cool == COOL_FULL);
        st.idle_lamp     = (cool == COOL_OFF);
        st.warn_lamp     = (temp_store > cfg_warn);
        return st;
    endfunction

    // item builders, unused fields get random content
    function automatic hvac_pkg::hvac_item_t make_tick(input bit btn,
                                                       input bit [hvac_pkg::POT_W-1:0] pot);
        hvac_pkg::hvac_item_t item;
        item.req_type     = hvac_pkg::REQ_TICK;
        item.button_level = btn;
        item.pot_value    = pot;
        item.temp_tenths  = hvac_pkg::TEMP_W'(int'($urandom_range(0, 1400)) - 400);
        item.temp_valid   = 1'($urandom_range(0, 1));
        return item;
    endfunction

    function automatic hvac_pkg::hvac_item_t make_sample(input int temp, input bit valid);
        hvac_pkg::hvac_item_t item;
        item.req_type     = hvac_pkg::REQ_SAMPLE;
        item.button_level = 1'($urandom_range(0, 1));
        item.pot_value    = hvac_pkg::POT_W'($urandom_range(0, 1023));
        item.temp_tenths  = temp[hvac_pkg::TEMP_W-1:0];
        item.temp_valid   = valid;
        return item;
    endfunction

    // send one item and record its expected status once accepted
    task automatic send_item(input hvac_pkg::hvac_item_t item);
        int gap;
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 99) < 4)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 2);
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        req_type     = item.req_type;
        button_level = item.button_level;
        pot_value    = item.pot_value;
        temp_tenths  = item.temp_tenths;
        temp_valid   = item.temp_valid;
        do
            @(posedge clk);
        while (in_stall);
        pending_status.push_back(thermostat_step(item));
    endtask

    // let everything in flight come out
    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input hvac_pkg::cfg_index_t idx,
                             input logic [hvac_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            hvac_pkg::REG_HYST:     cfg_hyst       = value[hvac_pkg::HYST_W-1:0];
            hvac_pkg::REG_LOCK:     cfg_lock       = value[hvac_pkg::LOCK_W-1:0];
            hvac_pkg::REG_RUNDOWN:  cfg_rundown    = value[hvac_pkg::RUNDOWN_W-1:0];
            hvac_pkg::REG_DEBOUNCE: cfg_debounce   = value[hvac_pkg::DEBOUNCE_W-1:0];
            hvac_pkg::REG_WARN:     cfg_warn       = value[hvac_pkg::TEMP_W-1:0];
            hvac_pkg::REG_CHANGE:   cfg_change_min = value[hvac_pkg::CHANGE_W-1:0];
            default:                ;
        endcase
    endtask

    task automatic set_thresholds(input int hyst, input int lock, input int rundown,
                                  input int debounce, input int warn, input int change);
        wait_for_results();
        write_reg(hvac_pkg::REG_HYST, hvac_pkg::CFG_DATA_W'(hyst));
        write_reg(hvac_pkg::REG_LOCK, hvac_pkg::CFG_DATA_W'(lock));
        write_reg(hvac_pkg::REG_RUNDOWN, hvac_pkg::CFG_DATA_W'(rundown));
        write_reg(hvac_pkg::REG_DEBOUNCE, hvac_pkg::CFG_DATA_W'(debounce));
        write_reg(hvac_pkg::REG_WARN, hvac_pkg::CFG_DATA_W'(warn));
        write_reg(hvac_pkg::REG_CHANGE, hvac_pkg::CFG_DATA_W'(change));
    endtask

    // reset values: auto, off, setpoint 250, cold and invalid samples
    task automatic test_power_on_defaults();
        send_item(make_sample(-400, 1'b1));
        send_item(make_sample(1000, 1'b0));
        send_item(make_tick(1'b1, 10'd0));
    endtask

    // pot full scale, mid scale and the change threshold on both sides
    task automatic test_setpoint_map();
        send_item(make_tick(1'b1, 10'd1023));
        send_item(make_tick(1'b1, 10'd511));
        send_item(make_tick(1'b1, 10'd541));
        send_item(make_tick(1'b1, 10'd549));
    endtask

    // full cooling, stop with lockout, rundown, fan only while locked, restart
    task automatic test_cooling_cycle();
        set_thresholds(10, 6, 3, 1, 300, 5);
        send_item(make_sample(1000, 1'b1));
        send_item(make_sample(245, 1'b1));
        send_item(make_sample(1000, 1'b1));
        repeat (3) send_item(make_tick(1'b1, 10'd549));
        send_item(make_sample(1000, 1'b1));
        send_item(make_sample(1000, 1'b1));
        repeat (3) send_item(make_tick(1'b1, 10'd549));
        send_item(make_sample(1000, 1'b1));
    endtask

    // auto to manual to off and back to auto
    task automatic test_mode_button();
        send_item(make_tick(1'b0, 10'd549));
        send_item(make_tick(1'b1, 10'd549));
        send_item(make_sample(200, 1'b1));
        send_item(make_tick(1'b0, 10'd549));
        send_item(make_sample(200, 1'b1));
        send_item(make_tick(1'b1, 10'd549));
        send_item(make_tick(1'b0, 10'd549));
    endtask

    // random ticks and samples with realistic button and pot behavior
    task automatic run_random(input int count);
        int t;
        int span;
        bit btn;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                // button held low briefly, released for longer than the debounce
                if (btn_hold <= 0)
                begin
                    btn_cur = ~btn_cur;
                    if (btn_cur)
                        btn_hold = $urandom_range(int'(cfg_debounce) + 1,
                                                  int'(cfg_debounce) + 60);
                    else
                        btn_hold = $urandom_range(1, 5);
                end
                btn_hold--;
                btn = btn_cur ^ ($urandom_range(0, 99) < 3);

                // pot drifts, with an occasional jump
                if ($urandom_range(0, 99) < 5)
                    pot_cur = $urandom_range(0, 1023);
                else
                    pot_cur = pot_cur + int'($urandom_range(0, 40)) - 20;
                if (pot_cur < 0)
                    pot_cur = 0;
                if (pot_cur > 1023)
                    pot_cur = 1023;
                send_item(make_tick(btn, pot_cur[hvac_pkg::POT_W-1:0]));
            end
            else
            begin
                // mostly around the hysteresis band, sometimes anywhere
                if ($urandom_range(0, 99) < 10)
                begin
                    t = int'($urandom_range(0, 1400)) - 400;
                end
                else
                begin
                    span = int'(cfg_hyst) + 15;
                    t = int'(setpoint) + int'($urandom_range(0, 2 * span)) - span;
                end
                send_item(make_sample(t, $urandom_range(0, 99) < 90));
            end
        end
    endtask

    task automatic test_random_settings();
        // quiet stretch, both sides never idle
        set_thresholds(20, 40, 15, 8, 260, 5);
        no_idle = 1'b1;
        run_random(250);
        no_idle = 1'b0;

        // all thresholds at their low end
        set_thresholds(0, 0, 0, 0, -400, 0);
        run_random(250);

        // all thresholds at their high end, presses never admitted
        set_thresholds(100, 262143, 32767, 1023, 1000, 140);
        run_random(200);

        repeat (3)
        begin
            set_thresholds($urandom_range(0, 100), $urandom_range(0, 300),
                           $urandom_range(0, 200), $urandom_range(0, 40),
                           int'($urandom_range(0, 1400)) - 400, $urandom_range(0, 140));
            run_random(280);
        end
    endtask

    // receiver stalls at random
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall = !no_idle && ($urandom_range(0, 99) < 6);
    end

    // compare each status item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                report_mismatch("status item with nothing expected", 1, 0);
            end
            else
            begin
                want_status = pending_status.pop_front();
                if (fan_on !== want_status.fan_on)
                    report_mismatch("fan_on", fan_on, want_status.fan_on);
                if (compressor_on !== want_status.compressor_on)
                    report_mismatch("compressor_on", compressor_on, want_status.compressor_on);
                if (cool_state !== want_status.cool_state)
                    report_mismatch("cool_state", cool_state, want_status.cool_state);
                if (mode_now !== want_status.mode_now)
                    report_mismatch("mode_now", mode_now, want_status.mode_now);
                if (locked_now !== want_status.locked_now)
                    report_mismatch("locked_now", locked_now, want_status.locked_now);
                if (setpoint_now !== want_status.setpoint_now)
                    report_mismatch("setpoint_now", setpoint_now, want_status.setpoint_now);
                if (cool_lamp !== want_status.cool_lamp)
                    report_mismatch("cool_lamp", cool_lamp, want_status.cool_lamp);
                if (idle_lamp !== want_status.idle_lamp)
                    report_mismatch("idle_lamp", idle_lamp, want_status.idle_lamp);
                if (warn_lamp !== want_status.warn_lamp)
                    report_mismatch("warn_lamp", warn_lamp, want_status.warn_lamp);
            end
        end
    end

    // watchdog on cycles where no item moves
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // reset, shadow defaults, then the tests in turn
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = hvac_pkg::REQ_TICK;
        button_level = 1'b1;
        pot_value    = '0;
        temp_tenths  = '0;
        temp_valid   = 1'b0;
        out_stall    = 1'b0;
        error_count  = 0;
        idle_cycles  = 0;
        no_idle      = 1'b0;
        btn_cur      = 1'b1;
        btn_hold     = 0;
        pot_cur      = 549;

        cfg_hyst       = 7'd20;
        cfg_lock       = 18'd180000;
        cfg_rundown    = 15'd30000;
        cfg_debounce   = 10'd250;
        cfg_warn       = 11'sd320;
        cfg_change_min = 8'd5;

        mode        = MODE_THERMO;
        cool        = COOL_OFF;
        fan         = 1'b0;
        comp        = 1'b0;
        locked      = 1'b0;
        since_stop  = '0;
        since_run   = '0;
        since_press = '0;
        prev_btn    = 1'b1;
        temp_store  = '0;
        setpoint    = hvac_pkg::SETPOINT_W'(hvac_pkg::SETPOINT_RESET);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_power_on_defaults();
        test_setpoint_map();
        test_cooling_cycle();
        test_mode_button();
        test_random_settings();

        wait_for_results();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
